### rtl/core/sqv_pkg.sv
// ============================================================================
// sqv_pkg
// Shared widths, register reset values and register indexes for the session
// query validator.
// ============================================================================
`default_nettype none

package sqv_pkg;

   // field widths
   localparam int ADDR_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int KEY_W       = 10;
   localparam int SLOT_OUT_W  = 4;
   localparam int QUERY_SLOTS = 4;
   localparam int QROW_W      = QUERY_SLOTS * BYTE_W;
   localparam int SLOT_SEL_W  = $clog2(QUERY_SLOTS);

   // table size default
   localparam int SESSION_COUNT_DEFAULT = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_ONE   = 2'd0,
      CSR_KEY_TWO   = 2'd1,
      CSR_KEY_THREE = 2'd2,
      CSR_KEY_FOUR  = 2'd3
   } csr_index_type;

   // key register reset values
   localparam logic [KEY_W-1:0] KEY_ONE_RESET   = 10'd428;
   localparam logic [KEY_W-1:0] KEY_TWO_RESET   = 10'd430;
   localparam logic [KEY_W-1:0] KEY_THREE_RESET = 10'd437;
   localparam logic [KEY_W-1:0] KEY_FOUR_RESET  = 10'd325;

   // input command codes
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

endpackage

`default_nettype wire

### rtl/core/session_query_validator_core.sv
// ============================================================================
// session_query_validator_core
// Session table keyed by client address; each session collects up to four
// query bytes whose sum is checked against four key registers.
// ============================================================================
// Flow: a clear command is answered straight from idle; a query runs a linear
// search over the sessions in use (one address memory read and compare per
// entry); a hit fills a slot and sums the row, a miss claims a free entry.
// Throughput: one item at a time, busy stays high until the result strobe and
// the next item is taken in the strobe cycle; results cannot be stalled.
// Reset empties the table (fill count to zero, no clearing pass), loads keys.
`default_nettype none

module session_query_validator_core
   import sqv_pkg::*;
#(
   parameter int SESSION_COUNT = SESSION_COUNT_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   // command channel
   input  wire                     start,
   output logic                    busy,
   input  wire                     req_command,
   input  wire  [ADDR_W-1:0]       req_client_address,
   input  wire  [BYTE_W-1:0]       req_query_byte,
   // result channel
   output logic                    rsp_valid,
   output logic                    rsp_validated,
   output logic [SLOT_OUT_W-1:0]   rsp_session_slot,
   output logic                    rsp_table_full,
   output logic [KEY_W-1:0]        rsp_query_sum,
   // configuration port
   input  wire                     csr_write_enable,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [KEY_W-1:0]        csr_write_data
);

   localparam int IDX_W = (SESSION_COUNT > 1) ? $clog2(SESSION_COUNT) : 1;
   localparam int CNT_W = $clog2(SESSION_COUNT + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SESSION_COUNT);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_CMP  = 7'b0000100,
      ST_FILL = 7'b0001000,
      ST_SUM  = 7'b0010000,
      ST_DONE = 7'b0100000,
      ST_MISS = 7'b1000000
   } state_type;

   // control state
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [SLOT_SEL_W-1:0]    slot_cnt_ff, slot_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload
   logic [ADDR_W-1:0]        req_addr_ff, req_addr_in;
   logic [BYTE_W-1:0]        req_byte_ff, req_byte_in;
   logic [QROW_W-1:0]        row_ff, row_in;
   logic [KEY_W-1:0]         sum_ff, sum_in;
   logic                     rsp_validated_ff, rsp_validated_in;
   logic [SLOT_OUT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                     rsp_full_ff, rsp_full_in;
   logic [KEY_W-1:0]         rsp_sum_ff, rsp_sum_in;

   // key registers
   logic [KEY_W-1:0]         key_one_ff, key_two_ff, key_three_ff, key_four_ff;

   // memories and their registered read data
   logic [ADDR_W-1:0]        addr_mem [SESSION_COUNT];
   logic [QROW_W-1:0]        query_mem [SESSION_COUNT];
   logic [ADDR_W-1:0]        addr_rd_ff;
   logic [QROW_W-1:0]        qrow_rd_ff;

   logic                     addr_we;
   logic                     qrow_we;
   logic [IDX_W-1:0]         wr_idx;
   logic [QROW_W-1:0]        qrow_wdata;

   logic [CNT_W-1:0]         scan_inc;
   logic [QROW_W-1:0]        row_filled;
   logic                     slot_taken;
   logic                     key_match;
   logic                     accept;

   assign accept   = start && (state_ff == ST_IDLE);
   assign scan_inc = CNT_W'(scan_ff) + CNT_W'(1);

   // put the byte into the first empty slot of the fetched row
   always_comb begin
      row_filled = qrow_rd_ff;
      slot_taken = 1'b0;
      for (int s = 0; s < QUERY_SLOTS; s++) begin
         if (!slot_taken && (qrow_rd_ff[s*BYTE_W +: BYTE_W] == '0)) begin
            row_filled[s*BYTE_W +: BYTE_W] = req_byte_ff;
            slot_taken = 1'b1;
         end
      end
   end

   assign key_match = (sum_ff == key_one_ff)   || (sum_ff == key_two_ff) ||
                      (sum_ff == key_three_ff) || (sum_ff == key_four_ff);

   // sequencer
   always_comb begin
      state_in         = state_ff;
      fill_in          = fill_ff;
      scan_in          = scan_ff;
      slot_cnt_in      = slot_cnt_ff;
      rsp_valid_in     = 1'b0;
      req_addr_in      = req_addr_ff;
      req_byte_in      = req_byte_ff;
      row_in           = row_ff;
      sum_in           = sum_ff;
      rsp_validated_in = rsp_validated_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_sum_in       = rsp_sum_ff;
      addr_we          = 1'b0;
      qrow_we          = 1'b0;
      wr_idx           = scan_ff;
      qrow_wdata       = row_filled;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_addr_in = req_client_address;
               req_byte_in = req_query_byte;
               scan_in     = '0;
               if (req_command == CMD_CLEAR) begin
                  // empty the table, answer with all-zero result
                  fill_in          = '0;
                  rsp_valid_in     = 1'b1;
                  rsp_validated_in = 1'b0;
                  rsp_slot_in      = '0;
                  rsp_full_in      = 1'b0;
                  rsp_sum_in       = '0;
               end else if (fill_ff == '0) begin
                  state_in = ST_MISS;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // memory read of entry scan in flight
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (addr_rd_ff == req_addr_ff) begin
               state_in = ST_FILL;
            end else if (scan_inc == fill_ff) begin
               state_in = ST_MISS;
            end else begin
               scan_in  = IDX_W'(scan_inc);
               state_in = ST_READ;
            end
         end
         ST_FILL: begin
            // write back the updated slots, then sum them
            qrow_we     = 1'b1;
            row_in      = row_filled;
            sum_in      = '0;
            slot_cnt_in = '0;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            sum_in      = sum_ff + KEY_W'(row_ff[slot_cnt_ff*BYTE_W +: BYTE_W]);
            slot_cnt_in = slot_cnt_ff + SLOT_SEL_W'(1);
            if (slot_cnt_ff == SLOT_SEL_W'(QUERY_SLOTS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in     = 1'b1;
            rsp_validated_in = key_match;
            rsp_slot_in      = SLOT_OUT_W'(scan_ff);
            rsp_full_in      = 1'b0;
            rsp_sum_in       = sum_ff;
            state_in         = ST_IDLE;
         end
         ST_MISS: begin
            rsp_valid_in     = 1'b1;
            rsp_validated_in = 1'b0;
            state_in         = ST_IDLE;
            if (fill_ff == FULL_COUNT) begin
               // no free entry: drop the query
               rsp_slot_in = '0;
               rsp_full_in = 1'b1;
               rsp_sum_in  = '0;
            end else begin
               // claim the next free entry
               addr_we     = 1'b1;
               qrow_we     = 1'b1;
               wr_idx      = IDX_W'(fill_ff);
               qrow_wdata  = QROW_W'(req_byte_ff);
               fill_in     = fill_ff + CNT_W'(1);
               rsp_slot_in = SLOT_OUT_W'(fill_ff);
               rsp_full_in = 1'b0;
               rsp_sum_in  = KEY_W'(req_byte_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         slot_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         slot_cnt_ff  <= slot_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_addr_ff      <= req_addr_in;
      req_byte_ff      <= req_byte_in;
      row_ff           <= row_in;
      sum_ff           <= sum_in;
      rsp_validated_ff <= rsp_validated_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_full_ff      <= rsp_full_in;
      rsp_sum_ff       <= rsp_sum_in;
   end

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_ff   <= KEY_ONE_RESET;
         key_two_ff   <= KEY_TWO_RESET;
         key_three_ff <= KEY_THREE_RESET;
         key_four_ff  <= KEY_FOUR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_ONE:   key_one_ff   <= csr_write_data;
            CSR_KEY_TWO:   key_two_ff   <= csr_write_data;
            CSR_KEY_THREE: key_three_ff <= csr_write_data;
            CSR_KEY_FOUR:  key_four_ff  <= csr_write_data;
            default:       key_one_ff   <= key_one_ff;
         endcase
      end
   end

   // session address memory
   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem[wr_idx] <= req_addr_ff;
      end
      addr_rd_ff <= addr_mem[scan_ff];
   end

   // session query-slot memory, one row of four bytes per entry
   always_ff @(posedge clock) begin
      if (qrow_we) begin
         query_mem[wr_idx] <= qrow_wdata;
      end
      qrow_rd_ff <= query_mem[scan_ff];
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_validated    = rsp_validated_ff;
   assign rsp_session_slot = rsp_slot_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_query_sum    = rsp_sum_ff;

   // checks
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("fill count beyond table size");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (fill_ff == FULL_COUNT))
      else $error("table full reported with free entries");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_CLEAR)) |=> (rsp_valid && (fill_ff == '0)))
      else $error("clear did not empty the table");

endmodule

`default_nettype wire
